@@ rtl/modexp_pkg.sv @@
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int WIDTH_DEFAULT = 32;

    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 2'd1;

    localparam int MODULUS_RESET  = 2;
    localparam int EXPONENT_RESET = 1;

    localparam int STATE_W = 3;

    typedef logic [STATE_W-1:0] t_state;

endpackage

@@ rtl/modular_exponentiation.sv @@
`timescale 1ns / 1ps

// Computes o_power = i_base ^ exponent mod modulus by right-to-left square and
// multiply. The user must set the modulus and exponent through the write port
// only while the block is idle; the block itself does not enforce it. An item
// is taken when start is high and busy is low. The result appears on o_power
// for exactly one cycle with o_valid high; the receiver cannot stall it and
// must take it then. Each modular product is formed one multiplier bit per
// cycle; the running result and the running square are formed side by side by
// two shift-and-add units that scan the same bits. An item first reduces the
// base, then makes one pass of the two units per exponent bit up to and
// including the highest set exponent bit. With a zero exponent, or a modulus
// below two, the answer (1 or 0) comes in the cycle after start. busy drops in
// the cycle after o_valid, and the next item may be started then.

module modular_exponentiation #(
    parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [modexp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [WIDTH-1:0]                  i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic [WIDTH-1:0]                  i_base,
    output logic                              o_valid,
    output logic [WIDTH-1:0]                  o_power
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    localparam modexp_pkg::t_state S_IDLE = 3'd0;
    localparam modexp_pkg::t_state S_RED  = 3'd1;
    localparam modexp_pkg::t_state S_LOAD = 3'd2;
    localparam modexp_pkg::t_state S_MUL  = 3'd3;
    localparam modexp_pkg::t_state S_DONE = 3'd4;

    logic [WIDTH-1:0]     r_modulus;
    logic [WIDTH-1:0]     r_exponent;
    modexp_pkg::t_state   r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [WIDTH-1:0]     r_eshift, n_eshift;
    logic [WIDTH-1:0]     r_mbits, n_mbits;
    logic [WIDTH-1:0]     r_acc, n_acc;
    logic [WIDTH-1:0]     r_b, n_b;
    logic [WIDTH-1:0]     r_p1, n_p1;
    logic [WIDTH-1:0]     r_p2, n_p2;

    logic [WIDTH-1:0]     p1_step;
    logic [WIDTH-1:0]     p2_step;
    logic [WIDTH-1:0]     p2_addend;
    logic                 mbit;

    // one shift-and-add step: (2p + bit*a) mod n, inputs below n
    function automatic logic [WIDTH-1:0] step_mod(
        input logic [WIDTH-1:0] p,
        input logic [WIDTH-1:0] a,
        input logic             b,
        input logic [WIDTH-1:0] n
    );
        logic [WIDTH+1:0] t;
        logic [WIDTH+1:0] n1;
        logic [WIDTH+1:0] n2;
        logic [WIDTH+1:0] res;
        t  = {1'b0, p, 1'b0} + {2'b00, (b ? a : {WIDTH{1'b0}})};
        n1 = {2'b00, n};
        n2 = {1'b0, n, 1'b0};
        if (t >= n2) begin
            res = t - n2;
        end else if (t >= n1) begin
            res = t - n1;
        end else begin
            res = t;
        end
        return res[WIDTH-1:0];
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= WIDTH'(modexp_pkg::MODULUS_RESET);
            r_exponent <= WIDTH'(modexp_pkg::EXPONENT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                modexp_pkg::REG_MODULUS: begin
                    r_modulus <= i_cfg_wdata;
                end
                modexp_pkg::REG_EXPONENT: begin
                    r_exponent <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign mbit      = r_mbits[WIDTH-1];
    assign p2_addend = (r_state == S_RED) ? WIDTH'(1) : r_b;
    assign p1_step   = step_mod(r_p1, r_acc, mbit, r_modulus);
    assign p2_step   = step_mod(r_p2, p2_addend, mbit, r_modulus);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_eshift = r_eshift;
        n_mbits  = r_mbits;
        n_acc    = r_acc;
        n_b      = r_b;
        n_p1     = r_p1;
        n_p2     = r_p2;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_eshift = r_exponent;
                    n_mbits  = i_base;
                    n_p2     = '0;
                    n_cnt    = '0;
                    if (r_exponent == '0) begin
                        n_acc   = WIDTH'(1);
                        n_state = S_DONE;
                    end else if (r_modulus < WIDTH'(2)) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RED;
                    end
                end
            end
            // base mod n, one base bit a cycle
            S_RED: begin
                n_p2    = p2_step;
                n_mbits = {r_mbits[WIDTH-2:0], 1'b0};
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_b     = p2_step;
                    n_acc   = WIDTH'(1);
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_mbits = r_b;
                n_p1    = '0;
                n_p2    = '0;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            // result times square and square times square, side by side
            S_MUL: begin
                n_p1    = p1_step;
                n_p2    = p2_step;
                n_mbits = {r_mbits[WIDTH-2:0], 1'b0};
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    if (r_eshift[0]) begin
                        n_acc = p1_step;
                    end
                    n_b      = p2_step;
                    n_eshift = {1'b0, r_eshift[WIDTH-1:1]};
                    if (r_eshift[WIDTH-1:1] == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eshift <= n_eshift;
        r_mbits  <= n_mbits;
        r_acc    <= n_acc;
        r_b      <= n_b;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_power = r_acc;

    a_one_word_per_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_start_goes_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    a_operands_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_acc < r_modulus && r_b < r_modulus))
        else $error("multiplier operands not reduced");

    a_partials_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_p1 < r_modulus && r_p2 < r_modulus))
        else $error("partial products not reduced");

    a_load_before_mul : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_MUL && r_cnt == '0))
        else $error("multiply pass did not start from a cleared count");

endmodule

@@ tb/modular_exponentiation_tb.sv @@
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    import modexp_pkg::*;

    localparam int W = WIDTH_DEFAULT;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 2 * (2 + W + (W + 1) * W);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [W-1:0]          i_cfg_wdata;
    logic                  start;
    logic                  busy;
    logic [W-1:0]          i_base;
    logic                  o_valid;
    logic [W-1:0]          o_power;

    logic [W-1:0] key_modulus;
    logic [W-1:0] key_exponent;
    logic [W-1:0] pending_powers[$];
    int           fail_count;
    int           cycle_count;

    modular_exponentiation #(
        .WIDTH(W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .start      (start),
        .busy       (busy),
        .i_base     (i_base),
        .o_valid    (o_valid),
        .o_power    (o_power)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // right to left square and multiply with full 64 bit products
    function automatic logic [W-1:0] mod_power(logic [W-1:0] b, logic [W-1:0] e,
                                               logic [W-1:0] n);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned m;
        if (e == '0) begin
            return 1;
        end
        if (n < 2) begin
            return '0;
        end
        m = n;
        sq = b % m;
        acc = 1;
        for (int i = 0; i < W; i++) begin
            if (e[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[W-1:0];
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modular_exponentiation verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic [W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (pending_powers.size() == 0) begin
                $error("unexpected word: power actual %h", o_power);
                fail_count++;
            end else begin
                want = pending_powers.pop_front();
                if (o_power !== want) begin
                    $error("power mismatch: expected %h actual %h", want, o_power);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [W-1:0] value);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = value;
        @(posedge i_clk);
        case (idx)
            REG_MODULUS:  key_modulus = value;
            REG_EXPONENT: key_exponent = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_key(logic [W-1:0] n, logic [W-1:0] e);
        write_reg(REG_MODULUS, n);
        write_reg(REG_EXPONENT, e);
    endtask

    task automatic send_base(logic [W-1:0] b, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
        end
        start = 1'b1;
        i_base = b;
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                break;
            end
        end
        pending_powers.push_back(mod_power(b, key_exponent, key_modulus));
        @(negedge i_clk);
        start = 1'b0;
        i_base = $urandom;
    endtask

    task automatic test_reset_key();
        send_base('0, 0);
        send_base(1, 0);
        send_base('1, 0);
    endtask

    task automatic test_spare_index();
        write_reg(REG_SPARE_LO, 32'h0000_0007);
        write_reg(REG_SPARE_HI, '0);
        send_base(5, 0);
    endtask

    task automatic test_edge_keys();
        set_key('1, '1);
        send_base('1, 0);
        send_base(32'hFFFF_FFFE, 0);
        send_base(2, 0);
        set_key(1, '0);
        send_base(7, 0);
        write_reg(REG_EXPONENT, 5);
        send_base(9, 0);
        write_reg(REG_MODULUS, '0);
        send_base(9, 0);
        write_reg(REG_EXPONENT, '0);
        send_base('1, 0);
        set_key(2, '1);
        send_base(3, 0);
        set_key(1000003, 65537);
        send_base(2 * 1000003 + 5, 0);
        send_base('0, 0);
        send_base(1, 0);
    endtask

    function automatic logic [W-1:0] pick_modulus();
        logic [W-1:0] n;
        case ($urandom_range(19))
            0:       n = $urandom_range(1);
            1, 2:    n = $urandom_range(20, 2);
            3:       n = '1 - $urandom_range(50);
            default: n = $urandom;
        endcase
        return n;
    endfunction

    function automatic logic [W-1:0] pick_exponent();
        logic [W-1:0] e;
        int len;
        if ($urandom_range(24) == 0) begin
            return '0;
        end
        len = $urandom_range(W, 1);
        e = $urandom;
        e = e & ({W{1'b1}} >> (W - len));
        e[len-1] = 1'b1;
        return e;
    endfunction

    function automatic logic [W-1:0] pick_base();
        logic [W-1:0] b;
        case ($urandom_range(9))
            0:       b = $urandom_range(3);
            1:       b = key_modulus + $urandom_range(3);
            2:       b = '1 - $urandom_range(3);
            default: b = $urandom;
        endcase
        return b;
    endfunction

    task automatic test_random_keys(int idle_pct, int n_items);
        int left_on_key;
        left_on_key = 0;
        for (int i = 0; i < n_items; i++) begin
            if (left_on_key == 0) begin
                set_key(pick_modulus(), pick_exponent());
                left_on_key = $urandom_range(15, 5);
            end
            send_base(pick_base(), idle_pct);
            left_on_key--;
        end
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        key_modulus = MODULUS_RESET;
        key_exponent = EXPONENT_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_MODULUS;
        i_cfg_wdata = '0;
        start = 1'b0;
        i_base = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_spare_index();
        test_edge_keys();
        test_random_keys(36, 92);
        test_random_keys(52, 92);
        test_random_keys(0, 92);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_powers.size() != 0) begin
            $error("power words still expected: %0d", pending_powers.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("modular_exponentiation verification clean");
        end else begin
            $display("modular_exponentiation verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
